// ----- hdl/sm3_hash_engine_assert.svh -----
// assertion macros used by the sm3 back module
// depends on nothing; included inside module bodies
`ifndef SM3_HASH_ENGINE_ASSERT_SVH
`define SM3_HASH_ENGINE_ASSERT_SVH

// implication checked every clock outside reset
`define SM3_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sm3 check failed");

// next-cycle implication checked outside reset
`define SM3_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sm3 check failed");

`endif

// ----- hdl/sm3_pkg.sv -----
// sm3 engine package: types, constants and round functions
// depends on nothing
package sm3_pkg;
  localparam int unsigned QueueDepth = 4;
  localparam logic [31:0] TjLow = 32'h79cc4519;
  localparam logic [31:0] TjHigh = 32'h7a879d8a;
  localparam logic [7:0] PadByte = 8'h80;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] state_t;

  typedef struct packed {
    word_t      data;
    logic       fin;
  } qitem_t;

  localparam state_t IV = {32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
                           32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f};

  function automatic word_t rotl(input word_t x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic word_t perm0(input word_t x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic word_t perm1(input word_t x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction
endpackage

// ----- hdl/sm3_if.sv -----
// valid/ready channel interface for the sm3 engine
// depends on nothing
interface sm3_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last_word;
  modport source(output valid, data_word, byte_count, last_word, input ready);
  modport sink(input valid, data_word, byte_count, last_word, output ready);
endinterface

interface sm3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        digest_done;
  modport source(output valid, digest_word, word_index, digest_done, input ready);
  modport sink(input valid, digest_word, word_index, digest_done, output ready);
endinterface

// ----- hdl/sm3_front.sv -----
// sm3 front: masks the last item, pads it when partial, pushes item into queue
// depends on sm3_pkg
module sm3_front (
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [31:0]    in_data_word,
  input  logic [2:0]     in_byte_count,
  input  logic           in_last_word,
  output logic           q_push,
  output sm3_pkg::qitem_t q_item,
  input  logic           q_full
);
  import sm3_pkg::*;

  logic [2:0] cnt;
  word_t keep;
  word_t padw;

  assign in_ready = !q_full;
  assign q_push = in_valid && in_ready;

  always_comb begin
    cnt = (!in_last_word || in_byte_count > 3'd4) ? 3'd4 : in_byte_count;
    keep = '0;
    padw = '0;
    unique case (cnt)
      3'd0: begin keep = 32'h0; padw = {PadByte, 24'h0}; end
      3'd1: begin keep = 32'hff000000; padw = {8'h0, PadByte, 16'h0}; end
      3'd2: begin keep = 32'hffff0000; padw = {16'h0, PadByte, 8'h0}; end
      3'd3: begin keep = 32'hffffff00; padw = {24'h0, PadByte}; end
      default: begin keep = 32'hffffffff; padw = '0; end
    endcase
    q_item.data = (in_data_word & keep) | padw;
    q_item.fin = in_last_word;
  end
  // the saturated byte count travels beside the item in the queue
endmodule

// ----- hdl/sm3_queue.sv -----
// short fifo between front and back
// depends on sm3_pkg
module sm3_queue #(
  parameter int unsigned Depth = sm3_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sm3_pkg::qitem_t din,
  input  logic [2:0]      din_cnt,
  output logic            full,
  input  logic            pop,
  output sm3_pkg::qitem_t dout,
  output logic [2:0]      dout_cnt,
  output logic            empty
);
  import sm3_pkg::*;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  qitem_t mem_r [Depth];
  logic [2:0] cmem_r [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] n_r;

  assign full = (n_r == (AW+1)'(Depth));
  assign empty = (n_r == '0);
  assign dout = mem_r[rp_r];
  assign dout_cnt = cmem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wp_r] <= din;
      cmem_r[wp_r] <= din_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; n_r <= '0;
    end else begin
      if (push && !full) wp_r <= (wp_r == AW'(Depth-1)) ? '0 : wp_r + 1'b1;
      if (pop && !empty) rp_r <= (rp_r == AW'(Depth-1)) ? '0 : rp_r + 1'b1;
      n_r <= n_r + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
    end
  end
endmodule

// ----- hdl/sm3_back.sv -----
// sm3 back: block buffer, expansion, 64 rounds, padding and digest output
// depends on sm3_pkg, sm3_out_if and the assertion header
module sm3_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  sm3_pkg::qitem_t q_item,
  input  logic [2:0]      q_cnt,
  output logic            q_pop,
  sm3_out_if.source       out
);
  import sm3_pkg::*;
  `include "sm3_hash_engine_assert.svh"

  localparam logic [2:0] S_TAKE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_RND  = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd3;
  localparam logic [2:0] S_FOLD = 3'd4;

  logic [2:0] st_r, st_nxt;
  state_t cv_r, r_r;
  word_t w_r [16];           // sliding window of expansion words
  logic [3:0] pos_r;
  logic [60:0] nbytes_r;
  logic [5:0] rnd_r;
  logic pad_r;               // finishing message
  logic padone_r;            // 0x80 already placed
  logic bits_written_r;      // length high word placed in this block
  logic [2:0] oidx_r;

  word_t push_w;
  logic  do_push;
  word_t wn, wj, wj4, tj, a12, ss1, ss2, ff, gg, tt1, tt2;
  logic [63:0] bits;

  assign bits = {nbytes_r, 3'b000};

  // word to push into the block buffer
  always_comb begin
    push_w = '0;
    do_push = 1'b0;
    q_pop = 1'b0;
    if (st_r == S_TAKE && !q_empty) begin
      do_push = 1'b1;
      q_pop = 1'b1;
      push_w = q_item.data;
    end else if (st_r == S_PAD) begin
      do_push = 1'b1;
      // length goes in only when slot 14 was free for its high word
      if (!padone_r) push_w = {PadByte, 24'h0};
      else if (pos_r == 4'd14) push_w = bits[63:32];
      else if (pos_r == 4'd15 && bits_written_r) push_w = bits[31:0];
      else push_w = '0;
    end
  end

  // one round
  always_comb begin
    wj  = w_r[0];
    wj4 = w_r[4];
    wn  = perm1(w_r[0] ^ w_r[7] ^ rotl(w_r[13], 5'd15)) ^ rotl(w_r[3], 5'd7) ^ w_r[10];
    tj  = rotl((rnd_r < 6'd16) ? TjLow : TjHigh, rnd_r[4:0]);
    a12 = rotl(r_r[0], 5'd12);
    ss1 = rotl(a12 + r_r[4] + tj, 5'd7);
    ss2 = ss1 ^ a12;
    if (rnd_r < 6'd16) begin
      ff = r_r[0] ^ r_r[1] ^ r_r[2];
      gg = r_r[4] ^ r_r[5] ^ r_r[6];
    end else begin
      ff = (r_r[0] & r_r[1]) | (r_r[0] & r_r[2]) | (r_r[1] & r_r[2]);
      gg = (r_r[4] & r_r[5]) | (~r_r[4] & r_r[6]);
    end
    tt1 = ff + r_r[3] + ss2 + (wj ^ wj4);
    tt2 = gg + r_r[7] + ss1 + wj;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_TAKE: if (!q_empty) begin
        if (pos_r == 4'd15) st_nxt = S_RND;
        else if (q_item.fin) st_nxt = S_PAD;
      end
      S_PAD: if (pos_r == 4'd15) st_nxt = S_RND;
      S_RND: if (rnd_r == 6'd63) st_nxt = S_FOLD;
      // more data, more padding, or digest ready
      S_FOLD: st_nxt = !pad_r ? S_TAKE : (bits_written_r ? S_OUT : S_PAD);
      S_OUT: if (out.ready && oidx_r == 3'd7) st_nxt = S_TAKE;
      default: st_nxt = S_TAKE;
    endcase
  end

  assign out.valid = (st_r == S_OUT);
  assign out.digest_word = cv_r[oidx_r];
  assign out.word_index = oidx_r;
  assign out.digest_done = (oidx_r == 3'd7);

  always_ff @(posedge clk) begin
    if (do_push) w_r[pos_r] <= push_w;
    if (st_r == S_RND) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wn;
    end
    if (st_r == S_RND) begin
      r_r[3] <= r_r[2]; r_r[2] <= rotl(r_r[1], 5'd9); r_r[1] <= r_r[0]; r_r[0] <= tt1;
      r_r[7] <= r_r[6]; r_r[6] <= rotl(r_r[5], 5'd19); r_r[5] <= r_r[4];
      r_r[4] <= perm0(tt2);
    end else begin
      r_r <= cv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_TAKE; cv_r <= IV; pos_r <= '0; nbytes_r <= '0; rnd_r <= '0;
      pad_r <= 1'b0; padone_r <= 1'b0; oidx_r <= '0;
    end else begin
      if (do_push) pos_r <= pos_r + 4'd1;
      if (st_r == S_TAKE && !q_empty) begin
        if (q_item.fin) begin
          nbytes_r <= nbytes_r + 61'(q_cnt);
          pad_r <= 1'b1;
          padone_r <= (q_cnt != 3'd4);
        end else begin
          nbytes_r <= nbytes_r + 61'd4;
        end
      end
      if (st_r == S_PAD) padone_r <= 1'b1;
      if (st_r == S_RND) rnd_r <= rnd_r + 6'd1;
      st_r <= st_nxt;
      if (st_r == S_FOLD) cv_r <= cv_r ^ r_r;
      if (st_r == S_OUT && out.ready) begin
        oidx_r <= oidx_r + 3'd1;
        if (oidx_r == 3'd7) begin
          cv_r <= IV; pos_r <= '0; nbytes_r <= '0; pad_r <= 1'b0; padone_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) bits_written_r <= 1'b0;
    else if (st_r == S_PAD && pos_r == 4'd14 && padone_r) bits_written_r <= 1'b1;
    else if (st_r == S_OUT) bits_written_r <= 1'b0;
  end

  `SM3_ASSERT_IMP(a_out_only_out, out.valid, st_r == S_OUT)
  `SM3_ASSERT_IMP(a_rnd_pos, st_r == S_RND, pos_r == 4'd0)
  `SM3_ASSERT_NEXT(a_fold_after, st_r == S_RND && rnd_r == 6'd63, st_r == S_FOLD)
  `SM3_ASSERT_IMP(a_no_pop, q_pop, st_r == S_TAKE)
endmodule

// ----- hdl/sm3_hash_engine.sv -----
// sm3 hash engine top level
// depends on sm3_pkg, sm3_if, sm3_front, sm3_queue, sm3_back
//
// usage: message words enter on in (data_word big-endian, last_word marks
// the final item, byte_count gives its 0..4 leading bytes). after the last
// item eight digest items leave on out, index 0 first, digest_done on 7.
// the front masks the last word, pads it when partial, and queues items;
// the back fills a 16-word block, then runs one compression round per
// cycle from a sliding 16-word expansion window, 64 rounds and then a fold.
// flow: the back takes items only while it fills a block and none while
// the single shared round unit runs the rounds and the fold; the queue
// (4 entries by default) holds items while the back is not taking them.
// the final item adds the rest of its block and at most one more padding
// block before the eight digest items.
// reset: synchronous active low, empties the queue and restores the
// initial chaining value. a stalled out ready holds the digest; the queue
// keeps taking items until it fills.
module sm3_hash_engine #(
  parameter int unsigned QDepth = sm3_pkg::QueueDepth
) (
  input logic        clk,
  input logic        rst_n,
  sm3_in_if.sink     in,
  sm3_out_if.source  out
);
  import sm3_pkg::*;

  logic   q_push, q_full, q_pop, q_empty;
  qitem_t q_in, q_out;
  logic [2:0] c_in, c_out;

  // saturated byte count of the item
  assign c_in = (!in.last_word || in.byte_count > 3'd4) ? 3'd4 : in.byte_count;

  sm3_front u_front (
    .in_valid(in.valid), .in_ready(in.ready), .in_data_word(in.data_word),
    .in_byte_count(in.byte_count), .in_last_word(in.last_word),
    .q_push, .q_item(q_in), .q_full
  );

  sm3_queue #(.Depth(QDepth)) u_queue (
    .clk, .rst_n, .push(q_push), .din(q_in), .din_cnt(c_in), .full(q_full),
    .pop(q_pop), .dout(q_out), .dout_cnt(c_out), .empty(q_empty)
  );

  sm3_back u_back (
    .clk, .rst_n, .q_empty, .q_item(q_out), .q_cnt(c_out), .q_pop, .out
  );
endmodule
